@@ hw/rtl/sact_pkg.sv @@
// ----------------------------------------------------------------------------
// sact_pkg
// Shared types, constants and helpers for the set-associative tag directory.
// ----------------------------------------------------------------------------
package sact_pkg;

  // Geometry. SETS is a power of two; the set index is taken modulo SETS.
  localparam int SETS  = 256;
  localparam int WAYS  = 4;
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Field widths.
  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int OFF_W      = 5;
  localparam int IDX_W      = 4;
  localparam int OUT_WAY_W  = 2;
  localparam int CFG_SEL_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_SEL_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_SEL_W-1:0] REG_INDEX_BITS  = 2'd1;

  localparam logic [OFF_W-1:0] OFFSET_BITS_RST = 5'd6;
  localparam logic [IDX_W-1:0] INDEX_BITS_RST  = 4'd8;

  // Access modes.
  localparam logic MODE_DEMAND   = 1'b0;
  localparam logic MODE_PREFETCH = 1'b1;

  typedef logic [WAY_W-1:0] way_t;
  typedef logic [SET_W-1:0] set_t;
  typedef logic [TAG_W-1:0] tag_t;

  typedef tag_t [WAYS-1:0] tag_row_t;

  // Per-set replacement state: position 0 of order is the most recent way.
  typedef struct packed {
    logic [WAYS-1:0] valid;
    way_t [WAYS-1:0] order;
  } set_state_t;

  typedef struct packed {
    logic hit;
    way_t way;
  } lookup_t;

  function automatic set_state_t reset_state();
    set_state_t st;
    st.valid = '0;
    for (int j = 0; j < WAYS; j++) begin
      st.order[j] = WAY_W'(WAYS - 1 - j);
    end
    return st;
  endfunction

endpackage

@@ hw/rtl/sact_ifs.sv @@
// ----------------------------------------------------------------------------
// sact channel interfaces
// Valid/ready channels for accesses, results and configuration writes.
// ----------------------------------------------------------------------------
interface sact_in_if import sact_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              mode;

  modport source (output valid, output address, output mode, input ready);
  modport sink   (input valid, input address, input mode, output ready);
endinterface

interface sact_out_if import sact_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [OUT_WAY_W-1:0] way;
  logic                 next_level_request;

  modport source (output valid, output hit, output way, output next_level_request,
                  input ready);
  modport sink   (input valid, input hit, input way, input next_level_request,
                  output ready);
endinterface

interface sact_cfg_if import sact_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_SEL_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/set_assoc_lru_cache_tags_unit.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_unit
// Tag directory of a set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
// Flow: an accepted access reads the set rows from the tag and state memories;
// the lookup then registers the result and writes the rows back together.
// A new access is refused while busy, until the previous write-back completes,
// which waits while the output register holds a result not yet taken.
// Reset: control state and the per-set init flags clear at once; a set whose
// flag is clear reads as all ways invalid in reset LRU order. No clearing pass.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags_unit import sact_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  sact_cfg_if.sink    cfg,
  sact_in_if.sink     access,
  sact_out_if.source  result
);

  // Configuration registers. The source must write them only while the unit is
  // idle; the unit does not enforce this. The channel is always ready.
  logic [OFF_W-1:0] offset_bits;
  logic [IDX_W-1:0] index_bits;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_BITS_RST;
      index_bits  <= INDEX_BITS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_OFFSET_BITS: offset_bits <= cfg.data[OFF_W-1:0];
        REG_INDEX_BITS:  index_bits  <= cfg.data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Address split happens in the accept cycle and drives the memory reads.
  set_t set_in;
  tag_t tag_in;

  sact_addr_split u_split (
    .address     (access.address),
    .offset_bits (offset_bits),
    .index_bits  (index_bits),
    .set_idx     (set_in),
    .tag         (tag_in)
  );

  // busy marks a transaction whose set rows are being read and updated.
  logic busy;
  logic accept;
  logic finish;
  set_t set_q;
  tag_t tag_q;
  logic mode_q;

  assign access.ready = !busy;
  assign accept       = access.valid && !busy;
  // The update completes only when the output register can take the result,
  // so a stalled result never lets the memories run ahead.
  assign finish       = busy && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_q  <= set_in;
      tag_q  <= tag_in;
      mode_q <= access.mode;
    end
  end

  // Set memories. Reads and writes never share a cycle: reads issue on
  // accept (idle) and writes on finish (busy), so no forwarding is needed.
  tag_row_t   tag_rd;
  tag_row_t   tag_wr;
  set_state_t st_rd_raw;
  set_state_t st_rd;
  set_state_t st_wr;
  lookup_t    lk;

  sact_ram #(
    .WIDTH ($bits(tag_row_t)),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (finish),
    .waddr (set_q),
    .wdata (tag_wr),
    .re    (accept),
    .raddr (set_in),
    .rdata (tag_rd)
  );

  sact_ram #(
    .WIDTH ($bits(set_state_t)),
    .DEPTH (SETS)
  ) u_state_ram (
    .clk   (clk),
    .we    (finish),
    .waddr (set_q),
    .wdata (st_wr),
    .re    (accept),
    .raddr (set_in),
    .rdata (st_rd_raw)
  );

  // One init flag per set: a set never written since reset reads as the
  // reset state instead of whatever the state memory holds.
  logic [SETS-1:0] set_init;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_init <= '0;
    end else if (finish) begin
      set_init[set_q] <= 1'b1;
    end
  end

  assign st_rd = set_init[set_q] ? st_rd_raw : reset_state();

  sact_lookup u_lookup (
    .tag          (tag_q),
    .tag_row      (tag_rd),
    .state        (st_rd),
    .result       (lk),
    .tag_row_next (tag_wr),
    .state_next   (st_wr)
  );

  // Output register: holds the result while the next access is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (finish) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.hit                <= lk.hit;
      result.way                <= OUT_WAY_W'(lk.way);
      result.next_level_request <= !lk.hit && (mode_q == MODE_DEMAND);
    end
  end

endmodule

@@ hw/rtl/sact_ram.sv @@
// ----------------------------------------------------------------------------
// sact_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/sact_addr_split.sv @@
// ----------------------------------------------------------------------------
// sact_addr_split
// Splits a byte address into set index and tag under the current geometry.
// ----------------------------------------------------------------------------
module sact_addr_split import sact_pkg::*; (
  input  logic [ADDR_W-1:0] address,
  input  logic [OFF_W-1:0]  offset_bits,
  input  logic [IDX_W-1:0]  index_bits,
  output set_t              set_idx,
  output tag_t              tag
);

  logic [ADDR_W-1:0] shifted;
  logic [ADDR_W-1:0] idx_mask;
  logic [OFF_W:0]    split;

  always_comb begin
    shifted  = address >> offset_bits;
    idx_mask = (ADDR_W'(1) << index_bits) - ADDR_W'(1);
    set_idx  = SET_W'(shifted & idx_mask & ADDR_W'(SETS - 1));
    split    = {1'b0, offset_bits} + (OFF_W + 1)'(index_bits);
    // A split at or past the address width leaves no tag bits.
    if (split >= (OFF_W + 1)'(ADDR_W)) begin
      tag = '0;
    end else begin
      tag = TAG_W'(address >> split[OFF_W-1:0]);
    end
  end

endmodule

@@ hw/rtl/sact_lookup.sv @@
// ----------------------------------------------------------------------------
// sact_lookup
// Tag compare over one set and LRU promotion; builds the write-back rows.
// ----------------------------------------------------------------------------
module sact_lookup import sact_pkg::*; (
  input  tag_t       tag,
  input  tag_row_t   tag_row,
  input  set_state_t state,
  output lookup_t    result,
  output tag_row_t   tag_row_next,
  output set_state_t state_next
);

  logic [WAYS-1:0] match;
  way_t            pos;
  way_t            w;

  always_comb begin
    for (int p = 0; p < WAYS; p++) begin
      match[p] = state.valid[state.order[p]] && (tag_row[state.order[p]] == tag);
    end

    // Most recent matching position wins; a miss takes the least recent.
    pos = WAY_W'(WAYS - 1);
    for (int p = WAYS - 1; p >= 0; p--) begin
      if (match[p]) begin
        pos = WAY_W'(p);
      end
    end

    w          = state.order[pos];
    result.hit = |match;
    result.way = w;

    state_next          = state;
    state_next.valid[w] = 1'b1;
    state_next.order[0] = w;
    for (int i = 1; i < WAYS; i++) begin
      if (WAY_W'(i) <= pos) begin
        state_next.order[i] = state.order[i - 1];
      end
    end

    tag_row_next    = tag_row;
    tag_row_next[w] = tag;
  end

endmodule
